@@ rtl/selective_ack_receive_window_unit_macros.svh @@
// Assertion macros shared by the selective ack receive window RTL.
// Depends on a clk_i and an active-low rst_ni in the including module.
`ifndef SELECTIVE_ACK_RECEIVE_WINDOW_UNIT_MACROS_SVH
`define SELECTIVE_ACK_RECEIVE_WINDOW_UNIT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SAR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/sar_pkg.sv @@
// Shared constants and types for the selective ack receive window.
// No dependencies.
package sar_pkg;

  localparam int SEQ_W          = 32;
  localparam int RX_WINDOW      = 256;
  localparam int WORD_W         = 64;
  localparam int WORDS          = RX_WINDOW / WORD_W;
  localparam int WADDR_W        = $clog2(WORDS);
  localparam int BIT_W          = $clog2(WORD_W);
  localparam int SLOT_W         = $clog2(RX_WINDOW);
  localparam int MAX_ACK_WINDOW = 64;
  localparam int WIN_W          = 7;
  localparam int PER_W          = 16;
  localparam int CNT_W          = 16;
  localparam int RUN_W          = BIT_W + 1;
  localparam int IDX_W          = 2;
  localparam int OUT_W          = 104;

  localparam logic [IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [IDX_W-1:0] REG_PERIOD = 2'd1;
  localparam logic [IDX_W-1:0] REG_START  = 2'd2;

  typedef enum logic [1:0] {
    CMD_RECV  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_GEN   = 2'd2,
    CMD_FORCE = 2'd3
  } cmd_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CHK  = 7'b0000010,
    ST_ARD  = 7'b0000100,
    ST_AEX  = 7'b0001000,
    ST_GB   = 7'b0010000,
    ST_GC   = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

endpackage

@@ rtl/selective_ack_receive_window_unit.sv @@
// Selective ack receive window: top level with command sequencer.
// Depends on sar_pkg, sar_ram and the assertion macro header.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser cmd, tdata seq_num
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata flags, ack_base, missing map
// cfg       in         cfg_we_i                       cfg_idx_i, cfg_data_i
//
// From an accepted command to the output state: a number at or below the base, an
// out-of-window number and force go directly; an in-window query or duplicate first reads
// its word. A new receive sets its bit, then advances the base through each 64-bit word it
// crosses in a read-modify-write loop on the single bitmap RAM. Generate reads two words.
// Reset clears the per-word valid bits, so the bitmap reads as empty with no clearing pass.
// The output register lets a new command enter while a result waits; the sequencer
// stalls only in its output state when a second result would overwrite an untaken one.
`include "selective_ack_receive_window_unit_macros.svh"

module selective_ack_receive_window_unit import sar_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SEQ_W-1:0]    s_axis_tdata,  // [31:0] seq_num
  input  logic [1:0]          s_axis_tuser,  // [1:0] cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] is_new, [1] is_dup, [2] beyond_window, [3] ack_due, [35:4] ack_base,
  // [99:36] missing_map, [103:100] zero
  output logic [OUT_W-1:0]    m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_idx_i,
  input  logic [SEQ_W-1:0]    cfg_data_i
);

  state_e             state_q, state_d;
  cmd_e               cmd_q, cmd_d, in_cmd;
  logic [SEQ_W-1:0]   seq_q, seq_d, base_q, base_d, b1, rem;
  logic [WIN_W-1:0]   win_q;
  logic [PER_W-1:0]   per_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [WORDS-1:0]   vld_q, vld_d;
  logic               rvld_q;
  logic [WORD_W-1:0]  lo_q, lo_d, rword, ram_rdata, ram_wdata;
  logic [WORD_W-1:0]  sh, clr, wmask, lmask, miss_q, miss_d;
  logic [2*WORD_W-1:0] pair;
  logic [WORD_W:0]    m65;
  logic               new_q, new_d, dup_q, dup_d, bey_q, bey_d;
  logic [WADDR_W-1:0] raddr, waddr;
  logic               ram_we, accept, out_load;
  logic [SEQ_W:0]     diff;
  logic [BIT_W-1:0]   p;
  logic [RUN_W-1:0]   run, adv, wl;
  logic               otv_q;
  logic [OUT_W-1:0]   otd_q;

  function automatic logic [RUN_W-1:0] trail_ones(input logic [WORD_W-1:0] w);
    logic [RUN_W-1:0] n;
    logic             stop;
    n    = '0;
    stop = 1'b0;
    for (int i = 0; i < WORD_W; i++) begin
      if (!stop && w[i]) begin
        n = n + RUN_W'(1);
      end else begin
        stop = 1'b1;
      end
    end
    return n;
  endfunction

  sar_ram #(.W(WORD_W), .DEPTH(WORDS)) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = cmd_e'(s_axis_tuser);
  assign b1            = base_q + SEQ_W'(1);
  assign rem           = ~base_q;
  assign p             = b1[BIT_W-1:0];
  assign diff          = {1'b0, s_axis_tdata} - {1'b0, base_q};
  assign rword         = rvld_q ? ram_rdata : '0;
  assign out_load      = (state_q == ST_OUT) && (!otv_q || m_axis_tready);

  // Advance step: length of the run of received numbers past the base in this word.
  assign sh  = rword >> p;
  assign run = trail_ones(sh);
  assign adv = (rem < SEQ_W'(run)) ? rem[RUN_W-1:0] : run;
  assign m65 = ((WORD_W+1)'(1) << adv) - (WORD_W+1)'(1);
  assign clr = m65[WORD_W-1:0] << p;

  // Generate step: two adjacent words hold the 64 numbers after the base.
  assign pair  = {rword, lo_q} >> p;
  assign wl    = (win_q > WIN_W'(MAX_ACK_WINDOW)) ? RUN_W'(MAX_ACK_WINDOW) : win_q[RUN_W-1:0];
  always_comb begin
    logic [WORD_W:0] t;
    logic [WORD_W:0] u;
    t     = ((WORD_W+1)'(1) << wl) - (WORD_W+1)'(1);
    u     = ((WORD_W+1)'(1) << rem[RUN_W-1:0]) - (WORD_W+1)'(1);
    wmask = t[WORD_W-1:0];
    lmask = (rem >= SEQ_W'(WORD_W)) ? '1 : u[WORD_W-1:0];
  end

  always_comb begin
    unique case (state_q)
      ST_IDLE: raddr = (in_cmd == CMD_GEN) ? b1[SLOT_W-1:BIT_W]
                                           : s_axis_tdata[SLOT_W-1:BIT_W];
      ST_GB:   raddr = b1[SLOT_W-1:BIT_W] + WADDR_W'(1);
      default: raddr = b1[SLOT_W-1:BIT_W];
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    seq_d     = seq_q;
    base_d    = base_q;
    cnt_d     = cnt_q;
    vld_d     = vld_q;
    lo_d      = lo_q;
    new_d     = new_q;
    dup_d     = dup_q;
    bey_d     = bey_q;
    miss_d    = miss_q;
    ram_we    = 1'b0;
    waddr     = seq_q[SLOT_W-1:BIT_W];
    ram_wdata = rword;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d  = in_cmd;
          seq_d  = s_axis_tdata;
          new_d  = 1'b0;
          dup_d  = 1'b0;
          bey_d  = 1'b0;
          miss_d = '0;
          unique case (in_cmd)
            CMD_RECV, CMD_QUERY: begin
              if (s_axis_tdata <= base_q) begin
                dup_d   = 1'b1;
                state_d = ST_OUT;
              end else if (diff > (SEQ_W+1)'(RX_WINDOW)) begin
                bey_d   = 1'b1;
                state_d = ST_OUT;
              end else begin
                state_d = ST_CHK;
              end
            end
            CMD_GEN: state_d = ST_GB;
            CMD_FORCE: begin
              cnt_d   = per_q;
              state_d = ST_OUT;
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_CHK: begin
        if (rword[seq_q[BIT_W-1:0]]) begin
          dup_d   = 1'b1;
          state_d = ST_OUT;
        end else if (cmd_q != CMD_RECV) begin
          state_d = ST_OUT;
        end else begin
          ram_we           = 1'b1;
          ram_wdata        = rword | (WORD_W'(1) << seq_q[BIT_W-1:0]);
          vld_d[waddr]     = 1'b1;
          new_d            = 1'b1;
          if (cnt_q != '1) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          state_d = ST_ARD;
        end
      end
      ST_ARD: state_d = ST_AEX;
      ST_AEX: begin
        ram_we    = 1'b1;
        waddr     = b1[SLOT_W-1:BIT_W];
        ram_wdata = rword & ~clr;
        base_d    = base_q + SEQ_W'(adv);
        // A run that reaches the end of the word continues in the next word.
        if (adv == RUN_W'(WORD_W) - RUN_W'(p) && base_d != '1) begin
          state_d = ST_ARD;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_GB: begin
        lo_d    = rword;
        state_d = ST_GC;
      end
      ST_GC: begin
        miss_d  = ~pair[WORD_W-1:0] & wmask & lmask;
        cnt_d   = '0;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i && cfg_idx_i == REG_START) begin
      base_d = cfg_data_i;
      vld_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      base_q  <= '0;
      cnt_q   <= '0;
      vld_q   <= '0;
      rvld_q  <= 1'b0;
      win_q   <= WIN_W'(32);
      per_q   <= PER_W'(8);
      otv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      cnt_q   <= cnt_d;
      vld_q   <= vld_d;
      rvld_q  <= vld_q[raddr];
      if (cfg_we_i && cfg_idx_i == REG_WINDOW) begin
        win_q <= cfg_data_i[WIN_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == REG_PERIOD) begin
        per_q <= cfg_data_i[PER_W-1:0];
      end
      if (out_load) begin
        otv_q <= 1'b1;
      end else if (m_axis_tready) begin
        otv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    seq_q  <= seq_d;
    lo_q   <= lo_d;
    new_q  <= new_d;
    dup_q  <= dup_d;
    bey_q  <= bey_d;
    miss_q <= miss_d;
    if (out_load) begin
      otd_q <= {4'b0, miss_q, base_q, (cnt_q >= per_q), bey_q, dup_q, new_q};
    end
  end

  assign m_axis_tvalid = otv_q;
  assign m_axis_tdata  = otd_q;

  `SAR_ASSERT(a_base_monotonic,
              !(cfg_we_i && cfg_idx_i == REG_START) |=> base_q >= $past(base_q),
              "base moved backward without a start_base write")
  `SAR_ASSERT(a_write_states,
              ram_we |-> (state_q == ST_CHK || state_q == ST_AEX),
              "bitmap written outside a read-modify-write step")
  `SAR_ASSERT(a_out_load,
              out_load |=> (m_axis_tvalid && state_q == ST_IDLE),
              "result load did not present a transfer and return to idle")
  `SAR_ASSERT_ALWAYS(a_ready_idle,
                     s_axis_tready |-> (state_q == ST_IDLE),
                     "input ready outside idle")

endmodule

@@ rtl/sar_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module sar_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 4,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ verif/selective_ack_receive_window_unit_tb.sv @@
// Testbench for the selective ack receive window unit: drives command transfers,
// predicts each result with its own window model and compares field by field.
// Depends on sar_pkg and the selective_ack_receive_window_unit RTL.
`timescale 1ns / 1ps

module selective_ack_receive_window_unit_tb;
  import sar_pkg::*;

  // Index that names no register; a write to it must change nothing.
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  // Members run from the highest bit down, matching the output tdata layout.
  typedef struct packed {
    logic [63:0] missing;
    logic [31:0] ack_base;
    logic        ack_due;
    logic        beyond;
    logic        is_dup;
    logic        is_new;
  } ack_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [SEQ_W-1:0]  s_axis_tdata = '0;  // [31:0] seq_num
  logic [1:0]        s_axis_tuser = '0;  // [1:0] cmd
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [0] is_new, [1] is_dup, [2] beyond_window, [3] ack_due, [35:4] ack_base,
  // [99:36] missing_map, [103:100] zero
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_we_i = 1'b0;
  logic [IDX_W-1:0]  cfg_idx_i = '0;
  logic [SEQ_W-1:0]  cfg_data_i = '0;

  selective_ack_receive_window_unit dut (.*);

  always #10 clk_i = ~clk_i;

  // Predictor state.
  logic [6:0]           win_size;
  logic [15:0]          period;
  logic [RX_WINDOW-1:0] seen_map;
  logic [31:0]          base;
  logic [15:0]          since_ack;

  ack_result_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  longint cycles = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("ERROR result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    errors++;
  endtask

  function automatic ack_result_t predict_ack(input cmd_e cmd, input logic [31:0] seq);
    ack_result_t r;
    int w;
    r = '0;
    if (cmd == CMD_RECV || cmd == CMD_QUERY) begin
      if (seq <= base) r.is_dup = 1'b1;
      else if (64'(seq) - 64'(base) > RX_WINDOW) r.beyond = 1'b1;
      else if (seen_map[seq[7:0]]) r.is_dup = 1'b1;
      else if (cmd == CMD_RECV) begin
        seen_map[seq[7:0]] = 1'b1;
        r.is_new = 1'b1;
        if (since_ack != 16'hFFFF) since_ack++;
        while (base != 32'hFFFF_FFFF && seen_map[8'(base + 1)]) begin
          seen_map[8'(base + 1)] = 1'b0;
          base++;
        end
      end
    end else if (cmd == CMD_GEN) begin
      w = (win_size > MAX_ACK_WINDOW) ? MAX_ACK_WINDOW : win_size;
      for (int i = 0; i < w; i++) begin
        if (64'(32'hFFFF_FFFF) - 64'(base) < i + 1) break;
        if (!seen_map[8'(base + 1 + i)]) r.missing[i] = 1'b1;
      end
      since_ack = '0;
    end else begin
      since_ack = period;
    end
    r.ack_due = since_ack >= period;
    r.ack_base = base;
    return r;
  endfunction

  always @(posedge clk_i) cycles++;
  always @(posedge clk_i) if (cycles > 400000) begin
    $display("timeout after %0d cycles", cycles);
    $display("selective_ack_receive_window_unit: mismatch");
    $finish;
  end

  // Result checker and receiver stalls.
  always @(posedge clk_i) begin
    ack_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[99:0];
      if (expected_q.size() == 0) begin
        report("unexpected result", m_axis_tdata[63:0], 64'(0));
      end else begin
        want = expected_q.pop_front();
        if (got.is_new !== want.is_new)
          report("is_new", 64'(got.is_new), 64'(want.is_new));
        if (got.is_dup !== want.is_dup)
          report("is_dup", 64'(got.is_dup), 64'(want.is_dup));
        if (got.beyond !== want.beyond)
          report("beyond_window", 64'(got.beyond), 64'(want.beyond));
        if (got.ack_due !== want.ack_due)
          report("ack_due", 64'(got.ack_due), 64'(want.ack_due));
        if (got.ack_base !== want.ack_base)
          report("ack_base", 64'(got.ack_base), 64'(want.ack_base));
        if (got.missing !== want.missing)
          report("missing_map", got.missing, want.missing);
      end
      results_seen++;
    end
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  end

  // Leaves tvalid high after the transfer; drain lowers it, as does the next call when it waits a gap.
  task automatic send_cmd(input cmd_e cmd, input logic [31:0] seq);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= seq;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q = {expected_q, predict_ack(cmd, seq)};
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_WINDOW: win_size = val[6:0];
      REG_PERIOD: period = val[15:0];
      REG_START: begin
        base = val;
        seen_map = '0;
      end
      default: ;
    endcase
  endtask

  task automatic test_directed;
    send_cmd(CMD_GEN, 32'h0);
    send_cmd(CMD_RECV, 32'd0);
    send_cmd(CMD_RECV, 32'd2);
    send_cmd(CMD_RECV, 32'd2);
    send_cmd(CMD_QUERY, 32'd2);
    send_cmd(CMD_QUERY, 32'd5);
    send_cmd(CMD_RECV, 32'd257);
    send_cmd(CMD_QUERY, 32'd300);
    send_cmd(CMD_RECV, 32'hFFFF_FFFF);
    send_cmd(CMD_GEN, 32'hFFFF_FFFF);
    send_cmd(CMD_RECV, 32'd1);
    send_cmd(CMD_FORCE, 32'hAAAA_5555);
    send_cmd(CMD_RECV, 32'd256);
    drain();
    write_reg(REG_START, 32'hFFFF_FFF0);
    write_reg(REG_WINDOW, 32'd64);
    write_reg(REG_PERIOD, 32'd0);
    send_cmd(CMD_RECV, 32'hFFFF_FFFF);
    send_cmd(CMD_GEN, 32'd0);
    for (int i = 1; i < 15; i++) send_cmd(CMD_RECV, 32'hFFFF_FFF0 + i);
    send_cmd(CMD_GEN, 32'd0);
    send_cmd(CMD_RECV, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_random_phase(input logic [6:0] w, input logic [15:0] p,
                                   input logic [31:0] start, input int n);
    logic [31:0] seq;
    int k;
    write_reg(REG_WINDOW, 32'(w));
    write_reg(REG_PERIOD, 32'(p));
    write_reg(REG_START, start);
    write_reg(REG_UNUSED, $urandom);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 60) seq = base + $urandom_range(1, 80);
      else if (k < 70) seq = base - $urandom_range(0, 20);
      else if (k < 78) seq = base + $urandom_range(200, 300);
      else seq = $urandom;
      if (k < 62) send_cmd(CMD_RECV, seq);
      else if (k < 80) send_cmd(CMD_QUERY, seq);
      else if (k < 94) send_cmd(CMD_GEN, $urandom);
      else send_cmd(CMD_FORCE, $urandom);
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    win_size = 7'd32;
    period = 16'd8;
    seen_map = '0;
    base = '0;
    since_ack = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_phase(7'd1, 16'd1, 32'd0, 104);
    test_random_phase(7'd127, 16'hFFFF, 32'h8000_0000, 104);
    test_random_phase(7'd0, 16'd3, 32'hFFFF_FF00, 104);
    test_random_phase(7'd40, 16'd8, $urandom, 104);
    test_random_phase(7'd64, 16'd12, 32'h7FFF_FFC0, 104);
    $display("Ran %0d commands and checked %0d results over directed edge cases",
             items_sent, results_seen);
    $display("and five random register settings.");
    if (errors == 0) $display("selective_ack_receive_window_unit: match");
    else $display("selective_ack_receive_window_unit: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sar_pkg.sv
rtl/sar_ram.sv
rtl/selective_ack_receive_window_unit.sv
verif/selective_ack_receive_window_unit_tb.sv
